// File: rtl/core/diff_drive_mixer_with_watchdog_core_defines.svh
// Assertion macros shared by the drive mixer RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef DIFF_DRIVE_MIXER_WITH_WATCHDOG_CORE_DEFINES_SVH
`define DIFF_DRIVE_MIXER_WITH_WATCHDOG_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ddm_pkg.sv
// Shared widths, codes and defaults of the differential drive mixer.
// No dependencies; used by the channel interfaces and the core.
package ddm_pkg;

  localparam int DUTY_BITS_DEF = 8;

  localparam int VEL_W      = 16;
  localparam int HWB_W      = 16;
  localparam int CPV_W      = 12;
  localparam int MIN_W      = 8;
  localparam int TMO_W      = 16;
  localparam int ELAPSED_W  = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Products and sums of the mixing path
  localparam int TURN_W     = VEL_W + HWB_W;       // ang * half wheel base, Q.28
  localparam int SPEED_W    = TURN_W + 2;          // lin<<16 +/- turn
  localparam int MAG_W      = SPEED_W - 1;         // magnitude of a wheel speed
  localparam int PROD_W     = MAG_W + CPV_W;       // magnitude * counts per velocity
  localparam int FRAC_SHIFT = 28;
  localparam int Q_W        = PROD_W - FRAC_SHIFT;
  localparam int CNT_W      = $clog2(HWB_W);

  localparam logic [HWB_W-1:0] HWB_RESET = 16'd6554;
  localparam logic [CPV_W-1:0] CPV_RESET = 12'd255;
  localparam logic [MIN_W-1:0] MIN_RESET = 8'd40;
  localparam logic [TMO_W-1:0] TMO_RESET = 16'd500;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_HALF_WHEEL_BASE = 2'd0,
    CFG_COUNTS_PER_VEL  = 2'd1,
    CFG_MIN_MOVE_DUTY   = 2'd2,
    CFG_CMD_TIMEOUT     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CMD  = 1'b1
  } opcode_t;

endpackage

// File: rtl/core/ddm_if.sv
// Valid/ready channel interfaces for command beats in and drive beats out.
// Depends on ddm_pkg for field widths.
interface ddm_in_if;
  logic                              valid;
  logic                              ready;
  logic                              opcode;
  logic signed [ddm_pkg::VEL_W-1:0]  linear_velocity;
  logic signed [ddm_pkg::VEL_W-1:0]  angular_velocity;

  modport source(output valid, opcode, linear_velocity, angular_velocity, input ready);
  modport sink(input valid, opcode, linear_velocity, angular_velocity, output ready);
endinterface

interface ddm_out_if #(
  parameter int DUTY_BITS = ddm_pkg::DUTY_BITS_DEF
);
  logic                 valid;
  logic                 ready;
  logic                 left_forward;
  logic                 left_reverse;
  logic [DUTY_BITS-1:0] left_duty;
  logic                 right_forward;
  logic                 right_reverse;
  logic [DUTY_BITS-1:0] right_duty;
  logic                 watchdog_braked;

  modport source(output valid, left_forward, left_reverse, left_duty, right_forward,
                 right_reverse, right_duty, watchdog_braked, input ready);
  modport sink(input valid, left_forward, left_reverse, left_duty, right_forward,
               right_reverse, right_duty, watchdog_braked, output ready);
endinterface

// File: rtl/core/diff_drive_mixer_with_watchdog_core.sv
// Differential drive mixer with command watchdog. A tick beat is accepted and then
// driven. A velocity command is accepted, then runs the bit-serial product of angular
// speed and half wheel base (one multiplier bit per cycle), mixes both wheel speeds,
// runs the bit-serial scaling by counts per velocity (both wheels side by side),
// clamps and drives. Input is taken only while idle; a finished result waits in the
// output register, and the next beat is accepted meanwhile, but the drive step stalls
// until the previous result has left. Configuration goes through cfg_we/cfg_addr/cfg_wdata.
// Depends on ddm_pkg, ddm_if and the assertion macro header.
`include "diff_drive_mixer_with_watchdog_core_defines.svh"

module diff_drive_mixer_with_watchdog_core #(
  parameter int DUTY_BITS = ddm_pkg::DUTY_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ddm_in_if.sink                          in_ch,
  ddm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ddm_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [ddm_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int TGT_W = DUTY_BITS + 1;
  localparam int FLW   = (DUTY_BITS > ddm_pkg::MIN_W) ? DUTY_BITS : ddm_pkg::MIN_W;
  localparam logic [DUTY_BITS-1:0]    DUTY_MAX = '1;
  localparam logic signed [TGT_W-1:0] TGT_MIN  = {1'b1, {DUTY_BITS{1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TURN  = 6'b000010,
    ST_MIX   = 6'b000100,
    ST_SCALE = 6'b001000,
    ST_CLAMP = 6'b010000,
    ST_DRIVE = 6'b100000
  } state_t;

  // configuration
  logic [ddm_pkg::HWB_W-1:0]     hwb_r;
  logic [ddm_pkg::CPV_W-1:0]     cpv_r;
  logic [ddm_pkg::MIN_W-1:0]     min_duty_r;
  logic [ddm_pkg::TMO_W-1:0]     timeout_r;

  // architectural state
  logic signed [TGT_W-1:0]       left_tgt_r, right_tgt_r;
  logic [ddm_pkg::ELAPSED_W-1:0] elapsed_r;
  state_t                        state_r;
  logic [ddm_pkg::CNT_W-1:0]     cnt_r;

  // datapath
  logic signed [ddm_pkg::VEL_W-1:0]   ang_r;
  logic signed [ddm_pkg::SPEED_W-1:0] linq_r, nlinq_r;
  logic [ddm_pkg::HWB_W-1:0]          hwb_sh_r;
  logic signed [ddm_pkg::TURN_W-1:0]  turn_r, turn_nxt;
  logic [ddm_pkg::CPV_W-1:0]          cpv_sh_r;
  logic [ddm_pkg::MAG_W-1:0]          lmag_r, rmag_r;
  logic                               lneg_r, rneg_r;
  logic [ddm_pkg::PROD_W-1:0]         lacc_r, racc_r, lacc_nxt, racc_nxt;

  // mixing
  logic signed [ddm_pkg::SPEED_W-1:0] turn_ext, dl, dl_n, dr, dr_n;
  logic [ddm_pkg::Q_W-1:0]            lq, rq;
  logic [DUTY_BITS-1:0]               lc, rc;
  logic signed [TGT_W-1:0]            ltgt_nxt, rtgt_nxt;

  // result register
  logic                 out_valid_r;
  logic                 out_lf_r, out_lr_r, out_rf_r, out_rr_r, out_wd_r;
  logic [DUTY_BITS-1:0] out_lduty_r, out_rduty_r;
  logic                 wd;
  logic [DUTY_BITS-1:0] lduty, rduty;

  logic in_fire;
  logic out_free;

  function automatic logic [DUTY_BITS-1:0] duty_of(input logic signed [TGT_W-1:0] tgt,
                                                   input logic [ddm_pkg::MIN_W-1:0] floor_v);
    logic [TGT_W-1:0] mag;
    logic [FLW-1:0]   m, mn, m2;
    mag = (tgt < 0) ? TGT_W'(-tgt) : TGT_W'(tgt);
    m   = FLW'(mag[DUTY_BITS-1:0]);
    mn  = FLW'(floor_v);
    m2  = (m < mn) ? mn : m;
    return (m2 > FLW'(DUTY_MAX)) ? DUTY_MAX : m2[DUTY_BITS-1:0];
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // one multiplier bit per cycle, MSB first
  assign turn_nxt = (turn_r <<< 1) +
                    (hwb_sh_r[ddm_pkg::HWB_W-1] ? ddm_pkg::TURN_W'(ang_r) : '0);
  assign lacc_nxt = {lacc_r[ddm_pkg::PROD_W-2:0], 1'b0} +
                    (cpv_sh_r[ddm_pkg::CPV_W-1] ? ddm_pkg::PROD_W'(lmag_r) : '0);
  assign racc_nxt = {racc_r[ddm_pkg::PROD_W-2:0], 1'b0} +
                    (cpv_sh_r[ddm_pkg::CPV_W-1] ? ddm_pkg::PROD_W'(rmag_r) : '0);

  // both signs of each wheel speed side by side; the sign picks the magnitude
  always_comb begin
    turn_ext = {{2{turn_r[ddm_pkg::TURN_W-1]}}, turn_r};
    dl   = linq_r - turn_ext;
    dl_n = turn_ext - linq_r;
    dr   = linq_r + turn_ext;
    dr_n = nlinq_r - turn_ext;
  end

  always_comb begin
    lq = lacc_r[ddm_pkg::PROD_W-1:ddm_pkg::FRAC_SHIFT];
    rq = racc_r[ddm_pkg::PROD_W-1:ddm_pkg::FRAC_SHIFT];
    lc = (lq > ddm_pkg::Q_W'(DUTY_MAX)) ? DUTY_MAX : lq[DUTY_BITS-1:0];
    rc = (rq > ddm_pkg::Q_W'(DUTY_MAX)) ? DUTY_MAX : rq[DUTY_BITS-1:0];
    ltgt_nxt = lneg_r ? -$signed({1'b0, lc}) : $signed({1'b0, lc});
    rtgt_nxt = rneg_r ? -$signed({1'b0, rc}) : $signed({1'b0, rc});
  end

  always_comb begin
    wd    = elapsed_r > timeout_r;
    lduty = duty_of(left_tgt_r, min_duty_r);
    rduty = duty_of(right_tgt_r, min_duty_r);
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hwb_r      <= ddm_pkg::HWB_RESET;
      cpv_r      <= ddm_pkg::CPV_RESET;
      min_duty_r <= ddm_pkg::MIN_RESET;
      timeout_r  <= ddm_pkg::TMO_RESET;
    end else if (cfg_we) begin
      case (ddm_pkg::cfg_idx_t'(cfg_addr))
        ddm_pkg::CFG_HALF_WHEEL_BASE: hwb_r      <= cfg_wdata[ddm_pkg::HWB_W-1:0];
        ddm_pkg::CFG_COUNTS_PER_VEL:  cpv_r      <= cfg_wdata[ddm_pkg::CPV_W-1:0];
        ddm_pkg::CFG_MIN_MOVE_DUTY:   min_duty_r <= cfg_wdata[ddm_pkg::MIN_W-1:0];
        ddm_pkg::CFG_CMD_TIMEOUT:     timeout_r  <= cfg_wdata[ddm_pkg::TMO_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      left_tgt_r  <= '0;
      right_tgt_r <= '0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // drop a taken beat; the drive step reloads the register itself
      if (out_valid_r && out_ch.ready && state_r != ST_DRIVE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.opcode == ddm_pkg::OP_CMD) begin
              elapsed_r <= '0;
              cnt_r     <= ddm_pkg::CNT_W'(ddm_pkg::HWB_W - 1);
              state_r   <= ST_TURN;
            end else begin
              if (elapsed_r != '1) begin
                elapsed_r <= elapsed_r + 1'b1;
              end
              state_r <= ST_DRIVE;
            end
          end
        end
        ST_TURN: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_MIX;
          end
        end
        ST_MIX: begin
          cnt_r   <= ddm_pkg::CNT_W'(ddm_pkg::CPV_W - 1);
          state_r <= ST_SCALE;
        end
        ST_SCALE: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          left_tgt_r  <= ltgt_nxt;
          right_tgt_r <= rtgt_nxt;
          state_r     <= ST_DRIVE;
        end
        ST_DRIVE: begin
          // hold until the previous result has left
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ang_r    <= in_ch.angular_velocity;
          linq_r   <= {{2{in_ch.linear_velocity[ddm_pkg::VEL_W-1]}},
                       in_ch.linear_velocity, {ddm_pkg::HWB_W{1'b0}}};
          nlinq_r  <= ddm_pkg::SPEED_W'(0) -
                      {{2{in_ch.linear_velocity[ddm_pkg::VEL_W-1]}},
                       in_ch.linear_velocity, {ddm_pkg::HWB_W{1'b0}}};
          hwb_sh_r <= hwb_r;
          turn_r   <= '0;
        end
      end
      ST_TURN: begin
        turn_r   <= turn_nxt;
        hwb_sh_r <= {hwb_sh_r[ddm_pkg::HWB_W-2:0], 1'b0};
      end
      ST_MIX: begin
        lneg_r   <= dl[ddm_pkg::SPEED_W-1];
        rneg_r   <= dr[ddm_pkg::SPEED_W-1];
        lmag_r   <= dl[ddm_pkg::SPEED_W-1] ? dl_n[ddm_pkg::MAG_W-1:0] : dl[ddm_pkg::MAG_W-1:0];
        rmag_r   <= dr[ddm_pkg::SPEED_W-1] ? dr_n[ddm_pkg::MAG_W-1:0] : dr[ddm_pkg::MAG_W-1:0];
        cpv_sh_r <= cpv_r;
        lacc_r   <= '0;
        racc_r   <= '0;
      end
      ST_SCALE: begin
        lacc_r   <= lacc_nxt;
        racc_r   <= racc_nxt;
        cpv_sh_r <= {cpv_sh_r[ddm_pkg::CPV_W-2:0], 1'b0};
      end
      ST_DRIVE: begin
        if (out_free) begin
          out_wd_r    <= wd;
          out_lf_r    <= !wd && (left_tgt_r > 0);
          out_lr_r    <= !wd && (left_tgt_r < 0);
          out_lduty_r <= (wd || left_tgt_r == '0) ? '0 : lduty;
          out_rf_r    <= !wd && (right_tgt_r > 0);
          out_rr_r    <= !wd && (right_tgt_r < 0);
          out_rduty_r <= (wd || right_tgt_r == '0) ? '0 : rduty;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.left_forward    = out_lf_r;
  assign out_ch.left_reverse    = out_lr_r;
  assign out_ch.left_duty       = out_lduty_r;
  assign out_ch.right_forward   = out_rf_r;
  assign out_ch.right_reverse   = out_rr_r;
  assign out_ch.right_duty      = out_rduty_r;
  assign out_ch.watchdog_braked = out_wd_r;

  `DDM_ASSERT_NEXT(a_cmd_clears_elapsed, in_fire && in_ch.opcode == ddm_pkg::OP_CMD,
                   elapsed_r == '0 && state_r == ST_TURN,
                   "command beat did not clear the elapsed counter")
  `DDM_ASSERT_NOW(a_wd_brakes_both, out_valid_r && out_wd_r,
                  !out_lf_r && !out_lr_r && !out_rf_r && !out_rr_r &&
                  out_lduty_r == '0 && out_rduty_r == '0,
                  "watchdog result drives a motor")
  `DDM_ASSERT_NOW(a_duty_matches_pins, out_valid_r,
                  (out_lduty_r == '0) == !(out_lf_r || out_lr_r) &&
                  (out_rduty_r == '0) == !(out_rf_r || out_rr_r),
                  "duty and direction pins disagree")
  `DDM_ASSERT_NOW(a_target_in_range, 1'b1,
                  left_tgt_r != TGT_MIN && right_tgt_r != TGT_MIN,
                  "wheel target outside the duty range")

endmodule

// File: test/testbench.sv
// Self-checking bench for the differential drive mixer with command watchdog.
// Depends on ddm_pkg, the ddm_in_if/ddm_out_if channels and the core RTL.
module testbench;

  localparam int DUTY_BITS = ddm_pkg::DUTY_BITS_DEF;
  localparam int TGT_W = DUTY_BITS + 1;
  localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;
  localparam int CYCLE_LIMIT = 300_000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic                 fwd;
    logic                 rev;
    logic [DUTY_BITS-1:0] duty;
  } motor_t;

  typedef struct packed {
    motor_t left;
    motor_t right;
    logic   wd_brake;
  } drive_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [ddm_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [ddm_pkg::CFG_DATA_W-1:0] cfg_wdata;

  ddm_in_if in_ch();
  ddm_out_if #(.DUTY_BITS(DUTY_BITS)) out_ch();

  diff_drive_mixer_with_watchdog_core #(.DUTY_BITS(DUTY_BITS)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  // Mirror of the block's registers and state
  logic [ddm_pkg::HWB_W-1:0] hwb_reg;
  logic [ddm_pkg::CPV_W-1:0] cpv_reg;
  logic [ddm_pkg::MIN_W-1:0] min_duty_reg;
  logic [ddm_pkg::TMO_W-1:0] timeout_reg;
  logic signed [TGT_W-1:0] left_tgt;
  logic signed [TGT_W-1:0] right_tgt;
  logic [ddm_pkg::ELAPSED_W-1:0] ms_since_cmd;

  drive_t drive_due[$];
  int send_idle_pct;
  int recv_stall_pct;
  bit any_mismatch;
  int unsigned cycle_count;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** diff_drive_mixer_with_watchdog_core: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Wheel speed in Q.28 to PWM counts: truncate toward zero, then clamp
  function automatic logic signed [TGT_W-1:0] wheel_counts(longint speed);
    longint mag;
    longint scale;
    longint q;
    scale = longint'(cpv_reg);
    mag = (speed < 0) ? -speed : speed;
    q = (mag * scale) >>> ddm_pkg::FRAC_SHIFT;
    if (q > DUTY_MAX) q = DUTY_MAX;
    return TGT_W'((speed < 0) ? -q : q);
  endfunction

  function automatic motor_t motor_drive(logic signed [TGT_W-1:0] tgt, logic brake);
    motor_t m;
    int mag;
    m = '0;
    if (brake || tgt == 0) return m;
    if (tgt > 0) begin
      m.fwd = 1'b1;
      mag = int'(tgt);
    end else begin
      m.rev = 1'b1;
      mag = -int'(tgt);
    end
    if (mag < int'(min_duty_reg)) mag = int'(min_duty_reg);
    if (mag > DUTY_MAX) mag = DUTY_MAX;
    m.duty = mag[DUTY_BITS-1:0];
    return m;
  endfunction

  task automatic predict_drive(ddm_pkg::opcode_t op, logic signed [ddm_pkg::VEL_W-1:0] lin,
                               logic signed [ddm_pkg::VEL_W-1:0] ang);
    longint lin_q;
    longint turn_q;
    longint span;
    drive_t d;
    if (op == ddm_pkg::OP_CMD) begin
      span = longint'(hwb_reg);
      lin_q = longint'(lin) * 65536;
      turn_q = longint'(ang) * span;
      left_tgt = wheel_counts(lin_q - turn_q);
      right_tgt = wheel_counts(lin_q + turn_q);
      ms_since_cmd = '0;
    end else if (ms_since_cmd != '1) begin
      ms_since_cmd = ms_since_cmd + 1'b1;
    end
    d.wd_brake = (ms_since_cmd > timeout_reg);
    d.left = motor_drive(left_tgt, d.wd_brake);
    d.right = motor_drive(right_tgt, d.wd_brake);
    drive_due.push_back(d);
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      any_mismatch = 1'b1;
    end
  endtask

  always @(posedge clk) begin : drive_check
    drive_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_due.size() == 0) begin
        $display("%0t: drive beat with none expected, expected nothing, got %b%b/%0d %b%b/%0d %b",
                 $time, out_ch.left_forward, out_ch.left_reverse, out_ch.left_duty,
                 out_ch.right_forward, out_ch.right_reverse, out_ch.right_duty,
                 out_ch.watchdog_braked);
        any_mismatch = 1'b1;
      end else begin
        want = drive_due.pop_front();
        check_field("left_forward", 16'(want.left.fwd), 16'(out_ch.left_forward));
        check_field("left_reverse", 16'(want.left.rev), 16'(out_ch.left_reverse));
        check_field("left_duty", 16'(want.left.duty), 16'(out_ch.left_duty));
        check_field("right_forward", 16'(want.right.fwd), 16'(out_ch.right_forward));
        check_field("right_reverse", 16'(want.right.rev), 16'(out_ch.right_reverse));
        check_field("right_duty", 16'(want.right.duty), 16'(out_ch.right_duty));
        check_field("watchdog_braked", 16'(want.wd_brake), 16'(out_ch.watchdog_braked));
      end
    end
  end

  // Return right after the accepting edge; valid stays high for a back-to-back beat
  task automatic send_item(ddm_pkg::opcode_t op, logic signed [ddm_pkg::VEL_W-1:0] lin,
                           logic signed [ddm_pkg::VEL_W-1:0] ang);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.linear_velocity = lin;
    in_ch.angular_velocity = ang;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_drive(op, lin, ang);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (drive_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(ddm_pkg::cfg_idx_t idx, logic [ddm_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      ddm_pkg::CFG_HALF_WHEEL_BASE: hwb_reg = value;
      ddm_pkg::CFG_COUNTS_PER_VEL:  cpv_reg = value[ddm_pkg::CPV_W-1:0];
      ddm_pkg::CFG_MIN_MOVE_DUTY:   min_duty_reg = value[ddm_pkg::MIN_W-1:0];
      ddm_pkg::CFG_CMD_TIMEOUT:     timeout_reg = value;
      default: ;
    endcase
  endtask

  function automatic logic signed [ddm_pkg::VEL_W-1:0] rand_word();
    return ddm_pkg::VEL_W'($urandom);
  endfunction

  function automatic logic signed [ddm_pkg::VEL_W-1:0] random_speed();
    case ($urandom_range(0, 7))
      0, 1: return rand_word();
      2: return '0;
      default: return ddm_pkg::VEL_W'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic test_reset_defaults();
    set_idling(14, 14);
    send_item(ddm_pkg::OP_TICK, 16'sh7FFF, -16'sd32768);
    send_item(ddm_pkg::OP_CMD, 16'sd4096, 16'sd0);
    send_item(ddm_pkg::OP_CMD, -16'sd2048, 16'sd4096);
    send_item(ddm_pkg::OP_CMD, 16'sd100, -16'sd100);
    send_item(ddm_pkg::OP_CMD, 16'sd0, 16'sd0);
    send_item(ddm_pkg::OP_TICK, 16'sd0, 16'sd0);
    wait_idle();
  endtask

  task automatic test_field_extremes();
    set_idling(0, 0);
    write_reg(ddm_pkg::CFG_HALF_WHEEL_BASE, 16'hFFFF);
    write_reg(ddm_pkg::CFG_COUNTS_PER_VEL, 16'd4095);
    send_item(ddm_pkg::OP_CMD, 16'sh7FFF, 16'sh7FFF);
    send_item(ddm_pkg::OP_CMD, -16'sd32768, -16'sd32768);
    send_item(ddm_pkg::OP_CMD, 16'sh7FFF, -16'sd32768);
    send_item(ddm_pkg::OP_CMD, 16'sd0, -16'sd32768);
    send_item(ddm_pkg::OP_CMD, -16'sd1, 16'sd1);
    wait_idle();
    // zero scale and zero base: every command yields a braking target
    write_reg(ddm_pkg::CFG_HALF_WHEEL_BASE, 16'd0);
    write_reg(ddm_pkg::CFG_COUNTS_PER_VEL, 16'd0);
    send_item(ddm_pkg::OP_CMD, 16'sh7FFF, 16'sh7FFF);
    wait_idle();
    // floor at the cap, then no floor at all
    write_reg(ddm_pkg::CFG_COUNTS_PER_VEL, ddm_pkg::CFG_DATA_W'(ddm_pkg::CPV_RESET));
    write_reg(ddm_pkg::CFG_MIN_MOVE_DUTY, 16'd255);
    send_item(ddm_pkg::OP_CMD, 16'sd64, 16'sd0);
    wait_idle();
    write_reg(ddm_pkg::CFG_MIN_MOVE_DUTY, 16'd0);
    send_item(ddm_pkg::OP_CMD, -16'sd64, 16'sd0);
    wait_idle();
  endtask

  task automatic test_zero_timeout();
    set_idling(0, 0);
    write_reg(ddm_pkg::CFG_HALF_WHEEL_BASE, ddm_pkg::HWB_RESET);
    write_reg(ddm_pkg::CFG_MIN_MOVE_DUTY, ddm_pkg::CFG_DATA_W'(ddm_pkg::MIN_RESET));
    write_reg(ddm_pkg::CFG_CMD_TIMEOUT, 16'd0);
    send_item(ddm_pkg::OP_CMD, 16'sd2048, -16'sd4096);
    send_item(ddm_pkg::OP_TICK, 16'sd1234, 16'sd77);
    send_item(ddm_pkg::OP_TICK, 16'sd0, 16'sd0);
    send_item(ddm_pkg::OP_CMD, -16'sd1024, 16'sd512);
    wait_idle();
  endtask

  task automatic test_timeout_boundary();
    int n;
    set_idling(0, 0);
    write_reg(ddm_pkg::CFG_CMD_TIMEOUT, 16'd3);
    send_item(ddm_pkg::OP_CMD, 16'sd4096, 16'sd1024);
    // brake only once the count passes the timeout, on the fourth tick
    for (n = 0; n < 6; n++) send_item(ddm_pkg::OP_TICK, rand_word(), rand_word());
    wait_idle();
    // the largest timeout never fires
    write_reg(ddm_pkg::CFG_CMD_TIMEOUT, 16'hFFFF);
    send_item(ddm_pkg::OP_TICK, 16'sd0, 16'sd0);
    send_item(ddm_pkg::OP_TICK, 16'sd0, 16'sd0);
    wait_idle();
  endtask

  task automatic random_config();
    logic [ddm_pkg::CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = 16'hFFFF;
      2: v = ddm_pkg::HWB_RESET;
      default: v = ddm_pkg::CFG_DATA_W'($urandom);
    endcase
    write_reg(ddm_pkg::CFG_HALF_WHEEL_BASE, v);
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = 16'd4095;
      2: v = ddm_pkg::CFG_DATA_W'(ddm_pkg::CPV_RESET);
      default: v = ddm_pkg::CFG_DATA_W'($urandom_range(0, 4095));
    endcase
    write_reg(ddm_pkg::CFG_COUNTS_PER_VEL, v);
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = 16'd255;
      2: v = ddm_pkg::CFG_DATA_W'(ddm_pkg::MIN_RESET);
      default: v = ddm_pkg::CFG_DATA_W'($urandom_range(0, 255));
    endcase
    write_reg(ddm_pkg::CFG_MIN_MOVE_DUTY, v);
    // keep the timeout short mostly so the watchdog trips often
    case ($urandom_range(0, 4))
      0: v = '0;
      1: v = 16'hFFFF;
      default: v = ddm_pkg::CFG_DATA_W'($urandom_range(0, 12));
    endcase
    write_reg(ddm_pkg::CFG_CMD_TIMEOUT, v);
  endtask

  task automatic test_random_traffic();
    int mode;
    int round;
    int n;
    for (mode = 0; mode < 4; mode++) begin
      case (mode)
        0: set_idling(0, 0);
        1: set_idling(59, 0);
        2: set_idling(0, 59);
        default: set_idling(14, 14);
      endcase
      for (round = 0; round < 2; round++) begin
        wait_idle();
        random_config();
        for (n = 0; n < 103; n++) begin
          if ($urandom_range(0, 99) < 35) begin
            send_item(ddm_pkg::OP_CMD, random_speed(), random_speed());
          end else begin
            send_item(ddm_pkg::OP_TICK, rand_word(), rand_word());
          end
        end
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.opcode = ddm_pkg::OP_TICK;
    in_ch.linear_velocity = '0;
    in_ch.angular_velocity = '0;
    out_ch.ready = 1'b0;
    any_mismatch = 1'b0;
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hwb_reg = ddm_pkg::HWB_RESET;
    cpv_reg = ddm_pkg::CPV_RESET;
    min_duty_reg = ddm_pkg::MIN_RESET;
    timeout_reg = ddm_pkg::TMO_RESET;
    left_tgt = '0;
    right_tgt = '0;
    ms_since_cmd = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_field_extremes();
    test_zero_timeout();
    test_timeout_boundary();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (!any_mismatch) begin
      $display("** diff_drive_mixer_with_watchdog_core: PASSED **");
    end else begin
      $display("** diff_drive_mixer_with_watchdog_core: FAILED **");
    end
    $finish;
  end

endmodule
